>>> sv/mh2_pkg.sv
// ----------------------------------------------------------------------------
// mh2_pkg
// Shared types and constants for the streaming MurmurHash2 core.
// ----------------------------------------------------------------------------
package mh2_pkg;

    localparam logic [31:0] MH2_MULT        = 32'h5bd1e995;
    localparam int          MH2_QUEUE_DEPTH = 2;

    // Work kind of a queued transaction
    typedef logic [1:0] mh2_kind_t;
    localparam mh2_kind_t KIND_FULL  = 2'd0;  // four bytes, full word mix
    localparam mh2_kind_t KIND_TAIL  = 2'd1;  // one to three bytes on a last item
    localparam mh2_kind_t KIND_EMPTY = 2'd2;  // last item carrying no bytes

    typedef struct packed {
        logic [31:0] word;   // bytes beyond the valid count already masked
        mh2_kind_t   kind;
        logic        last;
        logic        first;  // start of a message: seed replaces the hash
        logic [31:0] seed;
    } mh2_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mh2_qstat_t;

endpackage

>>> sv/mh2_front.sv
// ----------------------------------------------------------------------------
// mh2_front
// Accepts input transactions, drops stray partial words, masks tail bytes
// and marks message starts before handing work to the queue.
// ----------------------------------------------------------------------------
module mh2_front
    import mh2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    input  logic [31:0] message_length,
    input  mh2_qstat_t  qstat,
    output logic        push,
    output mh2_entry_t  push_entry
);

    logic        in_msg_reg;
    logic        in_msg_next;
    logic        accept;
    logic        drop;
    logic [31:0] mask;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;
    // Partial word that is not last carries no work at all
    assign drop     = (valid_bytes < 3'd4) && !last;
    assign push     = accept && !drop;

    always_comb
    begin
        unique case (valid_bytes)
            3'd0:    mask = 32'h0000_0000;
            3'd1:    mask = 32'h0000_00ff;
            3'd2:    mask = 32'h0000_ffff;
            3'd3:    mask = 32'h00ff_ffff;
            default: mask = 32'hffff_ffff;
        endcase
    end

    always_comb
    begin
        push_entry.word  = data_word & mask;
        push_entry.last  = last;
        push_entry.first = !in_msg_reg;
        push_entry.seed  = message_length;
        if (valid_bytes >= 3'd4)
        begin
            push_entry.kind = KIND_FULL;
        end
        else if (valid_bytes == 3'd0)
        begin
            push_entry.kind = KIND_EMPTY;
        end
        else
        begin
            push_entry.kind = KIND_TAIL;
        end
    end

    always_comb
    begin
        in_msg_next = in_msg_reg;
        if (push)
        begin
            in_msg_next = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_msg_reg <= 1'b0;
        end
        else
        begin
            in_msg_reg <= in_msg_next;
        end
    end

endmodule

>>> sv/mh2_queue.sv
// ----------------------------------------------------------------------------
// mh2_queue
// Short FIFO of classified transactions between front and back.
// ----------------------------------------------------------------------------
module mh2_queue
    import mh2_pkg::*;
#(
    parameter int DEPTH = MH2_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  mh2_entry_t push_entry,
    input  logic       pop,
    output mh2_entry_t head,
    output mh2_qstat_t qstat
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    mh2_entry_t    slots [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign qstat.full  = (count_reg == FULL_CNT);
    assign qstat.empty = (count_reg == '0);
    assign head        = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("queue read while empty");

endmodule

>>> sv/mh2_back.sv
// ----------------------------------------------------------------------------
// mh2_back
// Sequencer around one shared constant multiplier: word mix, hash update,
// tail step and finalizer, then the output register.
// ----------------------------------------------------------------------------
module mh2_back
    import mh2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mh2_qstat_t  qstat,
    input  mh2_entry_t  head,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_HMIX = 3'd3;
    localparam logic [2:0] ST_TAIL = 3'd4;
    localparam logic [2:0] ST_FIN1 = 3'd5;
    localparam logic [2:0] ST_FIN2 = 3'd6;

    logic [2:0]  st_reg;
    logic [2:0]  st_next;
    logic [31:0] h_reg;
    logic [31:0] h_next;
    logic [31:0] k_reg;
    logic [31:0] k_next;
    logic        last_reg;
    logic        last_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_hash_reg;
    logic [31:0] out_hash_next;
    logic [31:0] mul_a;
    logic [31:0] mul_p;
    logic        slot_free;

    assign out_valid  = out_valid_reg;
    assign hash_value = out_hash_reg;
    assign slot_free  = !out_valid_reg || out_ready;
    assign pop        = (st_reg == ST_IDLE) && !qstat.empty;

    // Operand select for the shared multiplier
    always_comb
    begin
        unique case (st_reg)
            ST_K1:   mul_a = k_reg;
            ST_K2:   mul_a = k_reg ^ (k_reg >> 24);
            ST_HMIX: mul_a = h_reg;
            ST_TAIL: mul_a = h_reg ^ k_reg;
            ST_FIN1: mul_a = h_reg ^ (h_reg >> 13);
            default: mul_a = h_reg;
        endcase
    end

    // Keep only the low 32 bits of the product
    assign mul_p = mul_a * MH2_MULT;

    always_comb
    begin
        st_next        = st_reg;
        h_next         = h_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        out_hash_next  = out_hash_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (st_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    h_next    = head.first ? head.seed : h_reg;
                    k_next    = head.word;
                    last_next = head.last;
                    unique case (head.kind)
                        KIND_FULL: st_next = ST_K1;
                        KIND_TAIL: st_next = ST_TAIL;
                        default:   st_next = ST_FIN1;
                    endcase
                end
            end
            ST_K1:
            begin
                k_next  = mul_p;
                st_next = ST_K2;
            end
            ST_K2:
            begin
                k_next  = mul_p;
                st_next = ST_HMIX;
            end
            ST_HMIX:
            begin
                h_next  = mul_p ^ k_reg;
                st_next = last_reg ? ST_FIN1 : ST_IDLE;
            end
            ST_TAIL:
            begin
                h_next  = mul_p;
                st_next = ST_FIN1;
            end
            ST_FIN1:
            begin
                h_next  = mul_p;
                st_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                // hold until the output register can take the result
                if (slot_free)
                begin
                    out_hash_next  = h_reg ^ (h_reg >> 15);
                    out_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        h_reg        <= h_next;
        k_reg        <= k_next;
        last_reg     <= last_next;
        out_hash_reg <= out_hash_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (st_reg == ST_IDLE))
        else $error("queue popped outside idle");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (st_reg != ST_IDLE))
        else $error("popped transaction not started");

    a_k1_to_k2: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_K1) |=> (st_reg == ST_K2))
        else $error("word mix sequence broken");

    a_fin_emits: assert property (@(posedge clk) disable iff (!rst_n)
        ((st_reg == ST_FIN2) && slot_free) |=> (out_valid_reg && (st_reg == ST_IDLE)))
        else $error("finished hash not registered");

endmodule

>>> sv/murmurhash2_stream_core.sv
// ----------------------------------------------------------------------------
// murmurhash2_stream_core
// Streaming 32-bit MurmurHash2 over little-endian message words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one word per transaction with its valid
// byte count and a last flag; message_length is taken as the seed on the
// first transaction of a message. A partial word that is not last is taken
// and dropped. Output channel (out_valid/out_ready): one hash_value per
// message, issued after its last transaction.
// Throughput: the back end owns a single 32x32 constant multiplier and runs
// one step per cycle, except while a finished hash waits for the output
// register: a full word takes a dequeue plus three multiplies, a tail word a
// dequeue and one multiply, and the finalizer a multiply and an output step.
// A dropped word costs an input transaction and no back-end time. An empty
// last word goes straight to the finalizer, others after their own steps.
// The front accepts while the queue (QUEUE_DEPTH entries) has room, so input
// keeps flowing while the back end works or a result waits.
// Reset clears the queue, the sequencer and the output register; the next
// transaction starts a new message. While out_ready is low the finished hash
// holds in the output register, the back end stalls on the next result and
// the queue fills, after which in_ready drops.
// ----------------------------------------------------------------------------
module murmurhash2_stream_core
    import mh2_pkg::*;
#(
    parameter int QUEUE_DEPTH = MH2_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    input  logic [31:0] message_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    mh2_qstat_t qstat;
    mh2_entry_t push_entry;
    mh2_entry_t head;
    logic       push;
    logic       pop;

    mh2_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_word      (data_word),
        .valid_bytes    (valid_bytes),
        .last           (last),
        .message_length (message_length),
        .qstat          (qstat),
        .push           (push),
        .push_entry     (push_entry)
    );

    mh2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    mh2_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .qstat      (qstat),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value)
    );

endmodule
